>>> rtl/sma_pkg.sv
// shared types and constants for the stack machine arithmetic unit
`timescale 1ns / 1ps

package sma_pkg;

  localparam int DATA_W          = 64;
  localparam int OP_W            = 3;
  localparam int STATUS_W        = 3;
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int CNT_W           = $clog2(DATA_W);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_ILLEGAL  = 3'd3,
    ST_DIVZERO  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

endpackage

>>> rtl/sma_stack.sv
// single-port stack memory with registered read data
`timescale 1ns / 1ps

module sma_stack #(
  parameter int DEPTH = sma_pkg::STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             addr,
  input  logic [sma_pkg::DATA_W-1:0] wdata,
  output logic [sma_pkg::DATA_W-1:0] rdata
);
  import sma_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sma_alu.sv
// iterative add/subtract/multiply/divide unit built around one 65-bit adder
`timescale 1ns / 1ps

module sma_alu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sma_pkg::alu_cmd_t          cmd,
  input  logic [sma_pkg::DATA_W-1:0] opa,
  input  logic [sma_pkg::DATA_W-1:0] opb,
  output logic                       done,
  output logic [sma_pkg::DATA_W-1:0] result
);
  import sma_pkg::*;

  typedef enum logic [6:0] {
    A_IDLE = 7'b0000001,
    A_ADD  = 7'b0000010,
    A_MUL  = 7'b0000100,
    A_NEGA = 7'b0001000,
    A_NEGB = 7'b0010000,
    A_DIV  = 7'b0100000,
    A_FIX  = 7'b1000000
  } alu_state_t;

  alu_state_t        state_r, state_nxt;
  alu_op_t           op_r, op_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] opd_r, opd_nxt;
  logic [DATA_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W-1:0] result_r, result_nxt;

  // the one shared adder
  logic [DATA_W:0]   add_x, add_y, sum;
  logic              add_cin;
  logic [DATA_W-1:0] shifted;
  logic              last;

  assign sum     = add_x + add_y + {{DATA_W{1'b0}}, add_cin};
  assign shifted = {acc_r[DATA_W-2:0], sh_r[DATA_W-1]};
  assign last    = (cnt_r == CNT_W'(DATA_W - 1));

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    acc_nxt    = acc_r;
    opd_nxt    = opd_r;
    sh_nxt     = sh_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    done_nxt   = 1'b0;
    result_nxt = result_r;
    add_x      = {1'b0, acc_r};
    add_y      = {1'b0, opd_r};
    add_cin    = 1'b0;

    case (state_r)
      A_IDLE: begin
        if (cmd.start) begin
          op_nxt  = cmd.op;
          cnt_nxt = '0;
          case (cmd.op)
            ALU_MUL: begin
              acc_nxt   = '0;
              opd_nxt   = opa;
              sh_nxt    = opb;
              state_nxt = A_MUL;
            end
            ALU_DIV: begin
              neg_nxt   = opa[DATA_W-1] ^ opb[DATA_W-1];
              sh_nxt    = opa;
              opd_nxt   = opb;
              state_nxt = A_NEGA;
            end
            default: begin
              acc_nxt   = opa;
              opd_nxt   = opb;
              state_nxt = A_ADD;
            end
          endcase
        end
      end
      A_ADD: begin
        if (op_r == ALU_SUB) begin
          add_y   = {1'b0, ~opd_r};
          add_cin = 1'b1;
        end
        result_nxt = sum[DATA_W-1:0];
        done_nxt   = 1'b1;
        state_nxt  = A_IDLE;
      end
      A_MUL: begin
        // shift-add, one multiplier bit a cycle, low word only
        if (sh_r[0]) begin
          acc_nxt = sum[DATA_W-1:0];
        end
        opd_nxt = {opd_r[DATA_W-2:0], 1'b0};
        sh_nxt  = {1'b0, sh_r[DATA_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          result_nxt = sh_r[0] ? sum[DATA_W-1:0] : acc_r;
          done_nxt   = 1'b1;
          state_nxt  = A_IDLE;
        end
      end
      A_NEGA: begin
        add_x   = '0;
        add_y   = {1'b0, ~sh_r};
        add_cin = 1'b1;
        if (sh_r[DATA_W-1]) begin
          sh_nxt = sum[DATA_W-1:0];
        end
        state_nxt = A_NEGB;
      end
      A_NEGB: begin
        add_x   = '0;
        add_y   = {1'b0, ~opd_r};
        add_cin = 1'b1;
        if (opd_r[DATA_W-1]) begin
          opd_nxt = sum[DATA_W-1:0];
        end
        acc_nxt   = '0;
        state_nxt = A_DIV;
      end
      A_DIV: begin
        // restoring step on magnitudes, borrow out means the trial failed
        add_x   = {1'b0, shifted};
        add_y   = {1'b1, ~opd_r};
        add_cin = 1'b1;
        acc_nxt = sum[DATA_W] ? shifted : sum[DATA_W-1:0];
        sh_nxt  = {sh_r[DATA_W-2:0], ~sum[DATA_W]};
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = A_FIX;
        end
      end
      A_FIX: begin
        add_x      = '0;
        add_y      = {1'b0, ~sh_r};
        add_cin    = 1'b1;
        result_nxt = neg_r ? sum[DATA_W-1:0] : sh_r;
        done_nxt   = 1'b1;
        state_nxt  = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    op_r     <= op_nxt;
    acc_r    <= acc_nxt;
    opd_r    <= opd_nxt;
    sh_r     <= sh_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    result_r <= result_nxt;
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

>>> rtl/stack_machine_alu.sv
// stack machine arithmetic unit: top-of-stack register, sequencer and result register
//
//   channel  direction  ports                                   transfer when
//   in       input      in_operation, in_operand                in_valid && in_ready
//   out      output     out_status, out_top_value, out_depth    out_valid && out_ready
//
// push, illegal, overflow and underflow finish in the transfer cycle; add and subtract
// pass through the read and execute states, and multiply and divide step the shared
// adder one bit a cycle. the top entry lives in a register, so a binary op reads one
// word from the single-port stack memory. no clearing pass after reset. in_ready drops
// while an op is in flight and while an untaken result holds the output register.
`timescale 1ns / 1ps

module stack_machine_alu #(
  parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [sma_pkg::OP_W-1:0]              in_operation,
  input  logic signed [sma_pkg::DATA_W-1:0]     in_operand,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sma_pkg::STATUS_W-1:0]          out_status,
  output logic signed [sma_pkg::DATA_W-1:0]     out_top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]      out_depth
);
  import sma_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_READ = 3'b010,
    T_EXEC = 3'b100
  } seq_state_t;

  seq_state_t        state_r, state_nxt;
  opcode_t           op_r, op_nxt;
  logic [DW-1:0]     sp_r, sp_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_top_r, out_top_nxt;
  logic [DW-1:0]     out_depth_r, out_depth_nxt;

  logic              ld;
  status_t           ld_status;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  alu_cmd_t          alu_cmd;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;
  logic [DW-1:0]     sp_m1, sp_m2;

  assign sp_m1    = sp_r - 1'b1;
  assign sp_m2    = sp_r - DW'(2);
  assign in_ready = (state_r == T_IDLE) && (!out_valid_r || out_ready);

  sma_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  sma_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (alu_cmd),
    .opa    (mem_rdata),
    .opb    (top_r),
    .done   (alu_done),
    .result (alu_result)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    sp_nxt     = sp_r;
    top_nxt    = top_r;
    ld         = 1'b0;
    ld_status  = ST_OK;
    mem_we     = 1'b0;
    mem_addr   = sp_m2[AW-1:0];
    mem_wdata  = top_r;
    alu_cmd    = '0;

    case (state_r)
      T_IDLE: begin
        if (in_valid && in_ready) begin
          case (opcode_t'(in_operation))
            OP_PUSH: begin
              ld = 1'b1;
              if (sp_r == DW'(STACK_DEPTH)) begin
                ld_status = ST_OVERFLOW;
              end else begin
                // old top spills into memory below the new top
                if (sp_r != '0) begin
                  mem_we   = 1'b1;
                  mem_addr = sp_m1[AW-1:0];
                end
                top_nxt = in_operand;
                sp_nxt  = sp_r + 1'b1;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (sp_r < DW'(2)) begin
                ld        = 1'b1;
                ld_status = ST_UNDERFLOW;
              end else begin
                op_nxt    = opcode_t'(in_operation);
                state_nxt = T_READ;
              end
            end
            default: begin
              ld        = 1'b1;
              ld_status = ST_ILLEGAL;
            end
          endcase
        end
      end
      T_READ: begin
        // second entry is on mem_rdata now
        if (op_r == OP_DIV && top_r == '0) begin
          top_nxt   = mem_rdata;
          sp_nxt    = sp_m1;
          ld        = 1'b1;
          ld_status = ST_DIVZERO;
          state_nxt = T_IDLE;
        end else begin
          alu_cmd.start = 1'b1;
          case (op_r)
            OP_ADD:  alu_cmd.op = ALU_ADD;
            OP_SUB:  alu_cmd.op = ALU_SUB;
            OP_MUL:  alu_cmd.op = ALU_MUL;
            default: alu_cmd.op = ALU_DIV;
          endcase
          state_nxt = T_EXEC;
        end
      end
      T_EXEC: begin
        if (alu_done) begin
          top_nxt   = alu_result;
          sp_nxt    = sp_m1;
          ld        = 1'b1;
          state_nxt = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ld) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ld_status;
      out_top_nxt    = (sp_nxt == '0) ? '0 : top_nxt;
      out_depth_nxt  = sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    top_r        <= top_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;

endmodule
